// ===== hw/rtl/blpa_pkg.sv =====
// ----------------------------------------------------------------------------
// blpa_pkg
// shared constants for the button long-press and auto-repeat block
// ----------------------------------------------------------------------------
package blpa_pkg;

    localparam int NUM_BUTTONS_DEF   = 7;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int BUTTON_W = 3;
    localparam int HOLD_W   = 16;
    localparam int TICKS_W  = 12;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam int THR_SHIFT = 3;

    localparam logic [TICKS_W-1:0]  LONG_PRESS_RST = 12'd100;
    localparam logic [TICKS_W-1:0]  MIN_REPEAT_RST = 12'd5;
    localparam logic [BUTTON_W-1:0] SET_IDX_RST    = 3'd1;
    localparam logic [BUTTON_W-1:0] RESET_IDX_RST  = 3'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REPEAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_IDX    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_IDX  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPEAT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG    = 2'd2;

endpackage

// ===== hw/rtl/button_long_press_autorepeat.sv =====
// ----------------------------------------------------------------------------
// button_long_press_autorepeat
// per-button hold counting with long-press events and accelerating repeat
//
//  channel | direction | handshake              | payload
//  s_axis  | in        | tvalid / tready        | tdata: button, level
//  m_axis  | out       | tvalid / tready        | tdata: button, tuser: kind
//  cfg     | in        | we (no wait)           | addr, wdata
//
//  one beat per cycle sustained while the output is not stalled; an event
//  reaches the output through the input register, then the result register
//  per-button state is one register read-modify-write per beat
//  synchronous active-low reset clears state and loads register defaults
//  an output stall holds the input register; input is taken again as soon
//  as the result register drains
// ----------------------------------------------------------------------------
module button_long_press_autorepeat
    import blpa_pkg::*;
#(
    parameter int NUM_BUTTONS   = NUM_BUTTONS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,   // button[2:0], level[3], zero
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [7:0]           o_m_axis_tdata,   // event_button[2:0], zero
    output logic [KIND_W-1:0]    o_m_axis_tuser,   // event_kind[1:0]
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [TICKS_W-1:0]   i_cfg_wdata
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int THR_W = HOLD_W + FRACTION_BITS;

    logic [TICKS_W-1:0]  r_long_ticks;
    logic [TICKS_W-1:0]  r_min_ticks;
    logic [BUTTON_W-1:0] r_set_idx;
    logic [BUTTON_W-1:0] r_reset_idx;

    logic [HOLD_W-1:0] r_hold [NUM_BUTTONS];
    logic [THR_W-1:0]  r_thr  [NUM_BUTTONS];
    logic [1:0]        r_fired;

    logic                r_in_valid;
    logic [BUTTON_W-1:0] r_in_button;
    logic                r_in_level;

    logic                r_out_valid;
    logic [BUTTON_W-1:0] r_out_button;
    logic [KIND_W-1:0]   r_out_kind;

    logic              advance;
    logic              in_range;
    logic [IDX_W-1:0]  idx;
    logic [HOLD_W-1:0] hold_cur;
    logic [HOLD_W-1:0] hold_inc;
    logic [THR_W-1:0]  thr_cur;
    logic [THR_W-1:0]  thr_dec;
    logic [THR_W-1:0]  thr_floor;
    logic [THR_W-1:0]  thr_reload;
    logic              is_set;
    logic              is_reset;
    logic              long_hit;

    logic [HOLD_W-1:0] n_hold;
    logic [THR_W-1:0]  n_thr;
    logic [1:0]        n_fired;
    logic              n_event;
    logic [KIND_W-1:0] n_kind;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(8 - BUTTON_W){1'b0}}, r_out_button};
    assign o_m_axis_tuser  = r_out_kind;

    assign in_range   = 32'(r_in_button) < NUM_BUTTONS;
    assign idx        = IDX_W'(r_in_button);
    assign hold_cur   = r_hold[idx];
    assign thr_cur    = r_thr[idx];
    assign hold_inc   = (hold_cur == {HOLD_W{1'b1}}) ? hold_cur : hold_cur + 1'b1;
    assign thr_floor  = THR_W'(r_min_ticks) << FRACTION_BITS;
    assign thr_reload = THR_W'(r_long_ticks) << FRACTION_BITS;
    assign thr_dec    = thr_cur - (thr_cur >> THR_SHIFT);
    assign is_set     = r_in_button == r_set_idx;
    assign is_reset   = r_in_button == r_reset_idx;
    assign long_hit   = hold_inc > HOLD_W'(r_long_ticks);

    always_comb begin
        n_hold  = hold_cur;
        n_thr   = thr_cur;
        n_fired = r_fired;
        n_event = 1'b0;
        n_kind  = KIND_RELEASE;
        if (!r_in_level) begin
            n_hold = hold_inc;
            if (is_set && long_hit) begin
                n_hold     = '0;
                n_fired[0] = 1'b1;
                n_event    = 1'b1;
                n_kind     = KIND_LONG;
            end else if (is_reset && long_hit) begin
                n_hold     = '0;
                n_fired[1] = 1'b1;
                n_event    = 1'b1;
                n_kind     = KIND_LONG;
            end else if ({hold_inc, {FRACTION_BITS{1'b0}}} > thr_cur) begin
                n_thr   = (thr_dec <= thr_floor) ? thr_floor : thr_dec;
                n_hold  = '0;
                n_event = 1'b1;
                n_kind  = KIND_REPEAT;
            end
        end else begin
            n_thr = thr_reload;
            if (hold_cur != '0) begin
                n_hold = '0;
                if (is_set && r_fired[0]) begin
                    n_fired[0] = 1'b0;
                end else if (is_reset && r_fired[1]) begin
                    n_fired[1] = 1'b0;
                end else begin
                    n_event = 1'b1;
                    n_kind  = KIND_RELEASE;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks <= LONG_PRESS_RST;
            r_min_ticks  <= MIN_REPEAT_RST;
            r_set_idx    <= SET_IDX_RST;
            r_reset_idx  <= RESET_IDX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LONG_PRESS: r_long_ticks <= i_cfg_wdata;
                CFG_MIN_REPEAT: r_min_ticks  <= i_cfg_wdata;
                CFG_SET_IDX:    r_set_idx    <= i_cfg_wdata[BUTTON_W-1:0];
                CFG_RESET_IDX:  r_reset_idx  <= i_cfg_wdata[BUTTON_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_button <= i_s_axis_tdata[BUTTON_W-1:0];
            r_in_level  <= i_s_axis_tdata[BUTTON_W];
        end
    end

    // per-button state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_hold[i] <= '0;
                r_thr[i]  <= THR_W'(LONG_PRESS_RST) << FRACTION_BITS;
            end
            r_fired <= '0;
        end else if (r_in_valid && advance && in_range) begin
            r_hold[idx] <= n_hold;
            r_thr[idx]  <= n_thr;
            r_fired     <= n_fired;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && in_range && n_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_button <= r_in_button;
            r_out_kind   <= n_kind;
        end
    end

endmodule

// ===== hw/rtl/blpa_checker.sv =====
// ----------------------------------------------------------------------------
// blpa_checker
// port-level checks for the button long-press and auto-repeat block
// ----------------------------------------------------------------------------
module blpa_checker
    import blpa_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [7:0]           o_m_axis_tdata,
    input logic [KIND_W-1:0]    o_m_axis_tuser
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output beat changed while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser == KIND_RELEASE || o_m_axis_tuser == KIND_REPEAT ||
             o_m_axis_tuser == KIND_LONG))
        else $error("illegal event kind");

    a_button_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> 32'(o_m_axis_tdata) < NUM_BUTTONS)
        else $error("event for a button out of range");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind button_long_press_autorepeat blpa_checker #(
    .NUM_BUTTONS(NUM_BUTTONS)
) u_blpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
